>>> design/crbw_pkg.sv
package crbw_pkg;

    localparam int COORD_W         = 24;
    localparam int EXT_W           = 23;
    localparam int DIFF_W          = 24;
    localparam int SQ_W            = 2 * DIFF_W + 1;
    localparam int ROOT_W          = (SQ_W + 1) / 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WIDTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd6;

    localparam logic [EXT_W-1:0] BLEND_RESET = 23'd256;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [EXT_W-1:0]   radius;
        logic        [EXT_W-1:0]   half_height;
        logic        [EXT_W-1:0]   blend_width;
        logic                      enable;
    } t_cfg;

    typedef struct packed {
        logic [DIFF_W-1:0] dz;
        logic              hit;
    } t_side;

endpackage

>>> design/crbw_front.sv
module crbw_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  crbw_pkg::t_cfg                      i_cfg,
    input  logic                                i_val,
    input  logic signed [crbw_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [crbw_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [crbw_pkg::COORD_W-1:0] i_pos_z,
    output logic                                o_val,
    output logic [crbw_pkg::SQ_W-1:0]           o_sq,
    output crbw_pkg::t_side                     o_side
);

    localparam int CW = crbw_pkg::COORD_W;
    localparam int DW = crbw_pkg::DIFF_W;
    localparam int EW = crbw_pkg::EXT_W;
    localparam int SW = crbw_pkg::SQ_W;

    function automatic logic [DW-1:0] abs_diff(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
        logic signed [CW:0] d;
        logic        [CW:0] m;
        d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
        m = d[CW] ? (~d + 1'b1) : d;
        return m[DW-1:0];
    endfunction

    logic              r_val_a, r_val_b, r_val_c;
    logic [DW-1:0]     r_dx, r_dy, r_dz_a, r_dz_b;
    logic [2*DW-1:0]   r_dx2, r_dy2;
    logic [2*EW-1:0]   r_rsq;
    logic [SW-1:0]     r_sq;
    logic [DW-1:0]     r_dz_c;
    logic              r_hit;
    logic [SW-1:0]     n_sq;

    assign n_sq = {1'b0, r_dx2} + {1'b0, r_dy2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_a <= 1'b0;
            r_val_b <= 1'b0;
            r_val_c <= 1'b0;
        end else if (i_en) begin
            r_val_a <= i_val;
            r_val_b <= r_val_a;
            r_val_c <= r_val_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx     <= abs_diff(i_pos_x, i_cfg.center_x);
            r_dy     <= abs_diff(i_pos_y, i_cfg.center_y);
            r_dz_a   <= abs_diff(i_pos_z, i_cfg.center_z);
            r_dx2    <= r_dx * r_dx;
            r_dy2    <= r_dy * r_dy;
            r_rsq    <= i_cfg.radius * i_cfg.radius;
            r_dz_b   <= r_dz_a;
            r_sq     <= n_sq;
            r_dz_c   <= r_dz_b;
            r_hit    <= i_cfg.enable && (r_dz_b < {1'b0, i_cfg.half_height})
                        && (n_sq < {{(SW-2*EW){1'b0}}, r_rsq});
        end
    end

    assign o_val      = r_val_c;
    assign o_sq       = r_sq;
    assign o_side.dz  = r_dz_c;
    assign o_side.hit = r_hit;

endmodule

>>> design/crbw_sqrt.sv
module crbw_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_val,
    input  logic [crbw_pkg::SQ_W-1:0]     i_sq,
    input  crbw_pkg::t_side               i_side,
    output logic                          o_val,
    output logic [crbw_pkg::ROOT_W-1:0]   o_root,
    output crbw_pkg::t_side               o_side
);

    localparam int N     = crbw_pkg::ROOT_W;
    localparam int RAD_W = 2 * N;
    localparam int REM_W = N + 2;

    logic             w_val  [0:N];
    logic [RAD_W-1:0] w_rad  [0:N];
    logic [REM_W-1:0] w_rem  [0:N];
    logic [N-1:0]     w_root [0:N];
    crbw_pkg::t_side  w_side [0:N];

    assign w_val[0]  = i_val;
    assign w_rad[0]  = {{(RAD_W-crbw_pkg::SQ_W){1'b0}}, i_sq};
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic             r_val;
        logic [RAD_W-1:0] r_rad;
        logic [REM_W-1:0] r_rem;
        logic [N-1:0]     r_root;
        crbw_pkg::t_side  r_side;
        logic [REM_W-1:0] cur, trial, n_rem;
        logic [N-1:0]     n_root;

        always_comb begin
            cur   = {w_rem[k][REM_W-3:0], w_rad[k][RAD_W-1 -: 2]};
            trial = {w_root[k], 2'b01};
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {w_root[k][N-2:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {w_root[k][N-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val <= 1'b0;
            end else if (i_en) begin
                r_val <= w_val[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= {w_rad[k][RAD_W-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                r_side <= w_side[k];
            end
        end

        assign w_val[k+1]  = r_val;
        assign w_rad[k+1]  = r_rad;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;
    end

    assign o_val  = w_val[N];
    assign o_root = w_root[N];
    assign o_side = w_side[N];

endmodule

>>> design/crbw_axis.sv
module crbw_axis #(
    parameter int WEIGHT_BITS = crbw_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_val,
    input  logic                          i_tag,
    input  logic [crbw_pkg::ROOT_W-1:0]   i_dist,
    input  logic [crbw_pkg::EXT_W-1:0]    i_outer,
    input  logic [crbw_pkg::EXT_W-1:0]    i_blend,
    output logic                          o_val,
    output logic                          o_tag,
    output logic [WEIGHT_BITS:0]          o_weight
);

    localparam int W   = WEIGHT_BITS;
    localparam int EW  = crbw_pkg::EXT_W;
    localparam int DW  = crbw_pkg::ROOT_W;
    localparam int RW  = EW + 1;
    localparam logic [W:0]   ONE   = {1'b1, {W{1'b0}}};
    localparam logic [W+1:0] THREE = {2'b11, {W{1'b0}}};

    logic [EW-1:0] inner;
    logic [DW-1:0] diff;
    logic          full0;

    assign inner = (i_outer > i_blend) ? (i_outer - i_blend) : '0;
    assign full0 = i_dist <= {{(DW-EW){1'b0}}, inner};
    assign diff  = i_dist - {{(DW-EW){1'b0}}, inner};

    logic          w_val  [0:W];
    logic          w_tag  [0:W];
    logic          w_full [0:W];
    logic [RW-1:0] w_rem  [0:W];
    logic [W-1:0]  w_q    [0:W];

    logic r_val0, r_tag0, r_full0;
    logic [RW-1:0] r_rem0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val0 <= 1'b0;
        end else if (i_en) begin
            r_val0 <= i_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag0  <= i_tag;
            r_full0 <= full0;
            r_rem0  <= full0 ? '0 : diff[RW-1:0];
        end
    end

    assign w_val[0]  = r_val0;
    assign w_tag[0]  = r_tag0;
    assign w_full[0] = r_full0;
    assign w_rem[0]  = r_rem0;
    assign w_q[0]    = '0;

    for (genvar k = 0; k < W; k++) begin : g_div
        logic          r_val, r_tag, r_full;
        logic [RW-1:0] r_rem;
        logic [W-1:0]  r_q;
        logic [RW:0]   cur;

        assign cur = {w_rem[k], 1'b0};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val <= 1'b0;
            end else if (i_en) begin
                r_val <= w_val[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag  <= w_tag[k];
                r_full <= w_full[k];
                if (cur >= {2'b00, i_blend}) begin
                    r_rem <= RW'(cur - {2'b00, i_blend});
                    r_q   <= {w_q[k][W-2:0], 1'b1};
                end else begin
                    r_rem <= cur[RW-1:0];
                    r_q   <= {w_q[k][W-2:0], 1'b0};
                end
            end
        end

        assign w_val[k+1]  = r_val;
        assign w_tag[k+1]  = r_tag;
        assign w_full[k+1] = r_full;
        assign w_rem[k+1]  = r_rem;
        assign w_q[k+1]    = r_q;
    end

    logic [2*W-1:0]   asq;
    logic [W-1:0]     r_a2;
    logic [W+1:0]     r_t;
    logic [2*W+1:0]   prod;
    logic [W+1:0]     r_s;
    logic [W:0]       r_w;
    logic             r_val1, r_val2, r_val3;
    logic             r_tag1, r_tag2, r_tag3;
    logic             r_full1, r_full2;

    assign asq  = w_q[W] * w_q[W];
    assign prod = r_a2 * r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val1 <= 1'b0;
            r_val2 <= 1'b0;
            r_val3 <= 1'b0;
        end else if (i_en) begin
            r_val1 <= w_val[W];
            r_val2 <= r_val1;
            r_val3 <= r_val2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a2    <= asq[2*W-1:W];
            r_t     <= THREE - {1'b0, w_q[W], 1'b0};
            r_tag1  <= w_tag[W];
            r_full1 <= w_full[W];
            r_s     <= prod[2*W+1:W];
            r_tag2  <= r_tag1;
            r_full2 <= r_full1;
            r_tag3  <= r_tag2;
            if (r_full2) begin
                r_w <= ONE;
            end else if (r_s > {1'b0, ONE}) begin
                r_w <= '0;
            end else begin
                r_w <= ONE - r_s[W:0];
            end
        end
    end

    assign o_val    = r_val3;
    assign o_tag    = r_tag3;
    assign o_weight = r_w;

endmodule

>>> design/cylinder_region_blend_weight.sv
// Throughput: one point per cycle while o_ready is high; o_ready drops while the
// two-entry output buffer is full and i_ready is low. The square root and the band
// divide are pipelined one result bit per stage, and the output buffer holds results.
// Reset (synchronous, active low) empties the pipeline and the output buffer and sets
// the configuration registers to 0, except blend_width, which resets to 1.0.
module cylinder_region_blend_weight #(
    parameter int FRAC_BITS   = crbw_pkg::FRAC_BITS_DEF,
    parameter int WEIGHT_BITS = crbw_pkg::WEIGHT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [crbw_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [crbw_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [crbw_pkg::COORD_W-1:0]   i_pos_x,
    input  logic signed [crbw_pkg::COORD_W-1:0]   i_pos_y,
    input  logic signed [crbw_pkg::COORD_W-1:0]   i_pos_z,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [WEIGHT_BITS:0]                  o_weight
);

    localparam int EW = crbw_pkg::EXT_W;
    localparam logic [EW-1:0] B_MIN = EW'(1) << FRAC_BITS;

    crbw_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{center_x: '0, center_y: '0, center_z: '0, radius: '0,
                       half_height: '0, blend_width: crbw_pkg::BLEND_RESET,
                       enable: 1'b0};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                crbw_pkg::CFG_CENTER_X:    r_cfg.center_x    <= i_cfg_data;
                crbw_pkg::CFG_CENTER_Y:    r_cfg.center_y    <= i_cfg_data;
                crbw_pkg::CFG_CENTER_Z:    r_cfg.center_z    <= i_cfg_data;
                crbw_pkg::CFG_RADIUS:      r_cfg.radius      <= i_cfg_data[EW-1:0];
                crbw_pkg::CFG_HALF_HEIGHT: r_cfg.half_height <= i_cfg_data[EW-1:0];
                crbw_pkg::CFG_BLEND_WIDTH: r_cfg.blend_width <= i_cfg_data[EW-1:0];
                crbw_pkg::CFG_ENABLE:      r_cfg.enable      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [EW-1:0] blend;
    assign blend = (r_cfg.blend_width < B_MIN) ? B_MIN : r_cfg.blend_width;

    logic                           en;
    logic                           f_val, s_val, z_val, xy_val, z_tag, xy_tag;
    logic [crbw_pkg::SQ_W-1:0]      f_sq;
    crbw_pkg::t_side                f_side, s_side;
    logic [crbw_pkg::ROOT_W-1:0]    s_root, z_dist;
    logic [WEIGHT_BITS:0]           wz, wxy, pw;
    logic [1:0]                     r_cnt;
    logic [WEIGHT_BITS:0]           r_buf0, r_buf1;
    logic                           push, pop;

    assign en      = (r_cnt != 2'd2) || i_ready;
    assign o_ready = en;

    crbw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_val   (i_valid),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .o_val   (f_val),
        .o_sq    (f_sq),
        .o_side  (f_side)
    );

    crbw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_val   (f_val),
        .i_sq    (f_sq),
        .i_side  (f_side),
        .o_val   (s_val),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    assign z_dist = {{(crbw_pkg::ROOT_W-crbw_pkg::DIFF_W){1'b0}}, s_side.dz};

    crbw_axis #(.WEIGHT_BITS(WEIGHT_BITS)) u_axis_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_val    (s_val),
        .i_tag    (s_side.hit),
        .i_dist   (z_dist),
        .i_outer  (r_cfg.half_height),
        .i_blend  (blend),
        .o_val    (z_val),
        .o_tag    (z_tag),
        .o_weight (wz)
    );

    crbw_axis #(.WEIGHT_BITS(WEIGHT_BITS)) u_axis_xy (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_val    (s_val),
        .i_tag    (s_side.hit),
        .i_dist   (s_root),
        .i_outer  (r_cfg.radius),
        .i_blend  (blend),
        .o_val    (xy_val),
        .o_tag    (xy_tag),
        .o_weight (wxy)
    );

    assign pw   = (z_tag && xy_tag && xy_val) ? ((wz < wxy) ? wz : wxy) : '0;
    assign push = en && z_val;
    assign pop  = (r_cnt != 2'd0) && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && pop) begin
            if (r_cnt == 2'd1) begin
                r_buf0 <= pw;
            end else begin
                r_buf0 <= r_buf1;
                r_buf1 <= pw;
            end
        end else if (pop) begin
            r_buf0 <= r_buf1;
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_buf0 <= pw;
            end else begin
                r_buf1 <= pw;
            end
        end
    end

    assign o_valid  = r_cnt != 2'd0;
    assign o_weight = r_buf0;

endmodule

>>> tb/sv/cylinder_region_blend_weight_test.sv
module cylinder_region_blend_weight_test;
    import crbw_pkg::*;

    localparam int WB = WEIGHT_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam longint W_ONE = 64'd1 << WB;
    localparam int LATENCY = 32 + WB;
    localparam int STALL_LIMIT = 2000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [COORD_W-1:0] i_pos_x;
    logic signed [COORD_W-1:0] i_pos_y;
    logic signed [COORD_W-1:0] i_pos_z;
    logic                      o_valid;
    logic                      i_ready;
    logic [WB:0]               o_weight;

    cylinder_region_blend_weight DUT (.*);

    t_cfg        cyl;
    logic [WB:0] weight_queue[$];
    int          error_count;
    int          idle_cycles;
    bit          sender_calm;
    bit          receiver_calm;
    bit          receiver_hold;
    bit          hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned abs_delta(longint a, longint b);
        return (a >= b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            if ((r | (64'd1 << k)) * (r | (64'd1 << k)) <= v)
                r = r | (64'd1 << k);
        end
        return r;
    endfunction

    function automatic longint unsigned band_weight(longint unsigned d,
        longint unsigned outer, longint unsigned b);
        longint unsigned inner, a, a2, s;
        inner = (outer > b) ? outer - b : 0;
        if (d <= inner)
            return W_ONE;
        a = ((d - inner) << WB) / b;
        if (a > W_ONE)
            a = W_ONE;
        a2 = (a * a) >> WB;
        s = (a2 * (3 * W_ONE - 2 * a)) >> WB;
        if (s > W_ONE)
            s = W_ONE;
        return W_ONE - s;
    endfunction

    function automatic logic [WB:0] cylinder_weight(logic signed [COORD_W-1:0] px,
        logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz);
        longint unsigned dx, dy, dz, b, sq, wz, wxy, r, h;
        dx = abs_delta(longint'(px), longint'(cyl.center_x));
        dy = abs_delta(longint'(py), longint'(cyl.center_y));
        dz = abs_delta(longint'(pz), longint'(cyl.center_z));
        r = cyl.radius;
        h = cyl.half_height;
        b = cyl.blend_width;
        if (b < (64'd1 << FB))
            b = 64'd1 << FB;
        if (!cyl.enable || dz >= h)
            return '0;
        sq = dx * dx + dy * dy;
        if (sq >= r * r)
            return '0;
        wz = band_weight(dz, h, b);
        wxy = band_weight(int_root(sq), r, b);
        return (wz < wxy) ? wz[WB:0] : wxy[WB:0];
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_CENTER_X:    cyl.center_x = val;
            CFG_CENTER_Y:    cyl.center_y = val;
            CFG_CENTER_Z:    cyl.center_z = val;
            CFG_RADIUS:      cyl.radius = val[EXT_W-1:0];
            CFG_HALF_HEIGHT: cyl.half_height = val[EXT_W-1:0];
            CFG_BLEND_WIDTH: cyl.blend_width = val[EXT_W-1:0];
            CFG_ENABLE:      cyl.enable = val[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (weight_queue.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic set_cylinder(int cx, int cy, int cz, int r, int h, int b, bit en);
        drain();
        write_reg(CFG_CENTER_X, CFG_DATA_W'(cx));
        write_reg(CFG_CENTER_Y, CFG_DATA_W'(cy));
        write_reg(CFG_CENTER_Z, CFG_DATA_W'(cz));
        write_reg(CFG_RADIUS, CFG_DATA_W'(r));
        write_reg(CFG_HALF_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_BLEND_WIDTH, CFG_DATA_W'(b));
        write_reg(CFG_ENABLE, CFG_DATA_W'(en));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_point(logic signed [COORD_W-1:0] px,
        logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz);
        if (!sender_calm) begin
            while ($urandom_range(99) < 9) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        weight_queue.push_back(cylinder_weight(px, py, pz));
        @(negedge i_clk);
    endtask

    function automatic int near(int c, int span);
        int v;
        v = c + $signed($urandom_range(2 * span)) - span;
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v;
    endfunction

    task automatic random_points(int count);
        int span;
        for (int n = 0; n < count; n++) begin
            span = int'(cyl.radius > cyl.half_height ? cyl.radius : cyl.half_height) + 300;
            if ($urandom_range(9) == 0)
                send_point(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            else
                send_point(COORD_W'(near(cyl.center_x, span)),
                           COORD_W'(near(cyl.center_y, span)),
                           COORD_W'(near(cyl.center_z, span)));
        end
    endtask

    task automatic test_reset_values();
        send_point(0, 0, 0);
        send_point(24'sh7FFFFF, -24'sh800000, 0);
    endtask

    task automatic test_directed_edges();
        set_cylinder(0, 0, 0, 2560, 1280, 512, 1'b1);
        send_point(0, 0, 0);
        send_point(2048, 0, 0);
        send_point(2049, 0, 0);
        send_point(0, 0, 768);
        send_point(0, 0, 769);
        send_point(2559, 0, 0);
        send_point(2560, 0, 0);
        send_point(0, 0, 1280);
        send_point(0, 0, -1279);
        send_point(1800, 1800, 0);
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_point(-24'sh800000, -24'sh800000, -24'sh800000);
        set_cylinder(0, 0, 0, 0, 1280, 256, 1'b1);
        send_point(0, 0, 0);
        set_cylinder(0, 0, 0, 2560, 0, 256, 1'b1);
        send_point(0, 0, 0);
        set_cylinder(0, 0, 0, 2560, 1280, 0, 1'b0);
        send_point(0, 0, 0);
        set_cylinder(-8388608, 8388607, -8388608, 8388607, 8388607, 8388607, 1'b1);
        send_point(0, 0, 0);
        send_point(-24'sh800000, 24'sh7FFFFF, -24'sh800000);
        send_point(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
        set_cylinder(8388607, -8388608, 8388607, 1000, 3000, 0, 1'b1);
        send_point(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
        send_point(24'sh7FFFF0, -24'sh800000, 24'sh7FF000);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 8; p++) begin
            set_cylinder(near(0, 8000000), near(0, 8000000), near(0, 8000000),
                $urandom_range(1, 20000), $urandom_range(1, 20000),
                (p % 3 == 0) ? $urandom_range(0, 300) : $urandom_range(0, 25000),
                ($urandom_range(7) != 0));
            random_points(200);
        end
    endtask

    task automatic test_backpressure();
        set_cylinder(100, -100, 50, 5000, 4000, 3000, 1'b1);
        hold_request = 1'b1;
        random_points(80);
        random_points(100);
        sender_calm = 1'b1;
        drain();
        random_points(20);
        sender_calm = 1'b0;
    endtask

    task automatic test_no_idle();
        set_cylinder(0, 0, 0, 3000, 3000, 2000, 1'b1);
        sender_calm = 1'b1;
        receiver_calm = 1'b1;
        random_points(200);
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
    endtask

    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                receiver_hold = 1'b1;
                i_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                receiver_hold = 1'b0;
                hold_done = 1'b1;
            end
            i_ready <= receiver_calm || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (weight_queue.size() == 0)
                report_mismatch("unexpected weight", o_weight, 0);
            else if (o_weight !== weight_queue[0]) begin
                report_mismatch("weight", o_weight, weight_queue[0]);
                void'(weight_queue.pop_front());
            end else
                void'(weight_queue.pop_front());
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n || receiver_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("cylinder_region_blend_weight_test: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_pos_z       = '0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        hold_request  = 1'b0;
        cyl = '{center_x: '0, center_y: '0, center_z: '0, radius: '0,
                half_height: '0, blend_width: BLEND_RESET, enable: 1'b0};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_values();
        test_directed_edges();
        test_random_settings();
        test_backpressure();
        test_no_idle();
        drain();
        if (error_count == 0)
            $display("cylinder_region_blend_weight_test: clean");
        else
            $display("cylinder_region_blend_weight_test: errors");
        $finish;
    end

endmodule

>>> filelist.f
design/crbw_pkg.sv
design/crbw_front.sv
design/crbw_sqrt.sv
design/crbw_axis.sv
design/cylinder_region_blend_weight.sv
tb/sv/cylinder_region_blend_weight_test.sv
